// ----- hw/rtl/pmt_pkg.sv -----
// Shared types and constants of the program map section parser.
`default_nettype none

package pmt_pkg;

    // Parse phase of the section walker.
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HEADER    = 3'd1,
        PH_PROG_DESC = 3'd2,
        PH_STREAM    = 3'd3,
        PH_ES_DESC   = 3'd4,
        PH_CRC       = 3'd5
    } t_phase;

    // Result kind codes as they leave the block.
    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_STREAM   = 2'd1,
        KIND_CRC      = 2'd2,
        KIND_BAD_TID  = 2'd3
    } t_kind;

    localparam logic [7:0]  PMT_TABLE_ID = 8'h02;
    localparam logic [11:0] HEADER_TAIL  = 12'd9;
    localparam logic [11:0] CRC_BYTES    = 12'd4;

    // Byte positions of interest inside the fixed header, the entries, the crc and the descriptors.
    localparam logic [3:0] POS_LEN_LO    = 4'd2;
    localparam logic [3:0] POS_HOLD_LO   = 4'd3;
    localparam logic [3:0] POS_HOLD_HI   = 4'd9;
    localparam logic [3:0] POS_HDR_LAST  = 4'd11;
    localparam logic [3:0] POS_ENT_LAST  = 4'd4;
    localparam logic [3:0] POS_CRC_LAST  = 4'd3;
    localparam logic [3:0] POS_DESC_TAG  = 4'd0;
    localparam logic [3:0] POS_DESC_LEN  = 4'd1;
    localparam logic [3:0] POS_DESC_BODY = 4'd2;

endpackage : pmt_pkg

`default_nettype wire

// ----- hw/rtl/pmt_stream_if.sv -----
// Valid/ready channels carrying section bytes in and parse results out.
`default_nettype none

interface pmt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       section_start;

    modport source (output valid, output data_byte, output section_start, input ready);
    modport sink   (input valid, input data_byte, input section_start, output ready);
endinterface : pmt_byte_if

interface pmt_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] prog_num;
    logic [4:0]  tbl_version;
    logic        current_next;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    logic [12:0] pcr_pid;
    logic [7:0]  entry_type;
    logic [12:0] entry_pid;
    logic [11:0] entry_desc_len;
    logic [31:0] crc_value;
    logic        last_of_section;

    modport source (
        output valid, input ready,
        output result_kind, output prog_num, output tbl_version,
        output current_next, output section_index, output last_section_index,
        output pcr_pid, output entry_type, output entry_pid,
        output entry_desc_len, output crc_value, output last_of_section
    );
    modport sink (
        input valid, output ready,
        input result_kind, input prog_num, input tbl_version,
        input current_next, input section_index, input last_section_index,
        input pcr_pid, input entry_type, input entry_pid,
        input entry_desc_len, input crc_value, input last_of_section
    );
endinterface : pmt_result_if

`default_nettype wire

// ----- hw/rtl/pmt_section_parser_core.sv -----
// Top level of the program map section parser: byte walker and result register.
`default_nettype none

// Channel   Dir  Handshake      Payload
// i_byte    in   valid/ready    data_byte[7:0], section_start
// o_res     out  valid/ready    result_kind[1:0], header fields, entry fields,
//                               crc_value[31:0], last_of_section
//
// One byte per clock unless stalled: the parse state and any result load at the
// accepting edge, so a result is offered in the cycle after its byte (at most one
// per byte). A waiting result stalls the input only while the sink holds ready low.
// Reset (i_rst_n low, synchronous) returns the walker to idle and empties the
// result register.

module pmt_section_parser_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pmt_byte_if.sink       i_byte,
    pmt_result_if.source   o_res
);
    import pmt_pkg::*;

    // Parse state.
    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [11:0] r_sbl, n_sbl;     // section bytes left
    logic [11:0] r_loop, n_loop;   // descriptor loop bytes left
    logic [7:0]  r_desc, n_desc;   // bytes left in current descriptor
    logic [39:0] r_fs, n_fs;       // field shifter: length words, entries, crc
    logic [55:0] r_hh, n_hh;       // header hold: program number .. pcr pid

    // Result register.
    logic        r_out_valid;
    t_kind       r_kind;
    logic [55:0] r_out_hh;
    logic [7:0]  r_st;
    logic [12:0] r_pid;
    logic [11:0] r_esl;
    logic [31:0] r_crc;
    logic        r_last;

    // Result produced by the byte being accepted.
    logic        emit;
    t_kind       e_kind;
    logic [7:0]  e_st;
    logic [12:0] e_pid;
    logic [11:0] e_esl;
    logic [31:0] e_crc;
    logic        e_last;

    logic        accept;
    logic        loop_done;
    logic        desc_end;
    logic [7:0]  b;

    // Take a byte whenever the result register is free or being drained.
    assign i_byte.ready = !r_out_valid || o_res.ready;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_sbl     = r_sbl;
        n_loop    = r_loop;
        n_desc    = r_desc;
        n_fs      = r_fs;
        n_hh      = r_hh;
        emit      = 1'b0;
        e_kind    = KIND_HEADER;
        e_st      = '0;
        e_pid     = '0;
        e_esl     = '0;
        e_crc     = '0;
        e_last    = 1'b0;
        loop_done = 1'b0;
        desc_end  = 1'b0;

        if (i_byte.section_start) begin
            // Abandon whatever was in progress.
            n_sbl  = '0;
            n_loop = '0;
            n_desc = '0;
            n_fs   = '0;
            n_hh   = '0;
            n_pos  = '0;
            if (b != PMT_TABLE_ID) begin
                n_phase = PH_IDLE;
                emit    = 1'b1;
                e_kind  = KIND_BAD_TID;
                e_last  = 1'b1;
            end else begin
                n_phase = PH_HEADER;
                n_pos   = 4'd1;
            end
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos >= POS_HOLD_LO && r_pos <= POS_HOLD_HI) begin
                        n_hh = {r_hh[47:0], b};
                    end else begin
                        n_fs = {r_fs[31:0], b};
                        if (r_pos == POS_LEN_LO) begin
                            n_sbl = n_fs[11:0];
                        end
                    end
                    if (r_pos < POS_HDR_LAST) begin
                        n_pos = r_pos + 4'd1;
                    end else begin
                        n_sbl  = (r_sbl > HEADER_TAIL) ? r_sbl - HEADER_TAIL : 12'd0;
                        n_loop = n_fs[11:0];
                        emit   = 1'b1;
                        e_kind = KIND_HEADER;
                        if (n_loop != 12'd0) begin
                            n_phase = PH_PROG_DESC;
                            n_pos   = POS_DESC_TAG;
                        end else begin
                            loop_done = 1'b1;
                        end
                    end
                end

                PH_PROG_DESC, PH_ES_DESC: begin
                    // Skip descriptors: tag, length, then body.
                    if (r_sbl != 12'd0) n_sbl = r_sbl - 12'd1;
                    if (r_loop != 12'd0) n_loop = r_loop - 12'd1;
                    if (r_pos == POS_DESC_TAG) begin
                        n_pos = POS_DESC_LEN;
                    end else if (r_pos == POS_DESC_LEN) begin
                        n_desc   = b;
                        n_pos    = POS_DESC_BODY;
                        desc_end = (b == 8'd0);
                    end else begin
                        if (r_desc != 8'd0) n_desc = r_desc - 8'd1;
                        desc_end = (n_desc == 8'd0);
                    end
                    if (desc_end) begin
                        if (n_loop != 12'd0) n_pos = POS_DESC_TAG;
                        else                 loop_done = 1'b1;
                    end
                end

                PH_STREAM: begin
                    if (r_sbl != 12'd0) n_sbl = r_sbl - 12'd1;
                    n_fs = {r_fs[31:0], b};
                    if (r_pos < POS_ENT_LAST) begin
                        n_pos = r_pos + 4'd1;
                    end else begin
                        emit   = 1'b1;
                        e_kind = KIND_STREAM;
                        e_st   = n_fs[39:32];
                        e_pid  = n_fs[28:16];
                        e_esl  = n_fs[11:0];
                        n_loop = n_fs[11:0];
                        if (n_loop != 12'd0) begin
                            n_phase = PH_ES_DESC;
                            n_pos   = POS_DESC_TAG;
                        end else begin
                            loop_done = 1'b1;
                        end
                    end
                end

                PH_CRC: begin
                    n_fs = {r_fs[31:0], b};
                    if (r_pos < POS_CRC_LAST) begin
                        n_pos = r_pos + 4'd1;
                    end else begin
                        emit    = 1'b1;
                        e_kind  = KIND_CRC;
                        e_crc   = n_fs[31:0];
                        e_last  = 1'b1;
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                    end
                end

                default: begin
                    // Idle: drop bytes until a section start.
                end
            endcase

            // Loop finished: more entries while over four bytes remain, else crc.
            if (loop_done) begin
                n_pos   = '0;
                n_fs    = '0;
                n_phase = (n_sbl > CRC_BYTES) ? PH_STREAM : PH_CRC;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_sbl   <= '0;
            r_loop  <= '0;
            r_desc  <= '0;
            r_fs    <= '0;
            r_hh    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sbl   <= n_sbl;
            r_loop  <= n_loop;
            r_desc  <= n_desc;
            r_fs    <= n_fs;
            r_hh    <= n_hh;
        end
    end

    // Result valid: load on a new result, clear once the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; the header hold is already zero on a wrong table id.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_kind   <= e_kind;
            r_out_hh <= n_hh;
            r_st     <= e_st;
            r_pid    <= e_pid;
            r_esl    <= e_esl;
            r_crc    <= e_crc;
            r_last   <= e_last;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.result_kind        = r_kind;
    assign o_res.prog_num           = r_out_hh[55:40];
    assign o_res.tbl_version        = r_out_hh[37:33];
    assign o_res.current_next       = r_out_hh[32];
    assign o_res.section_index      = r_out_hh[31:24];
    assign o_res.last_section_index = r_out_hh[23:16];
    assign o_res.pcr_pid            = r_out_hh[12:0];
    assign o_res.entry_type         = r_st;
    assign o_res.entry_pid          = r_pid;
    assign o_res.entry_desc_len     = r_esl;
    assign o_res.crc_value          = r_crc;
    assign o_res.last_of_section    = r_last;

endmodule : pmt_section_parser_core

`default_nettype wire

// ----- tb/tb_pmt_section_parser_core.sv -----
// Testbench of the program map section parser: byte walk predictor, scoreboard and drivers.
`default_nettype none

module tb_pmt_section_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pmt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int MAX_GAP      = 17;
    localparam int ITEM_TARGET  = 1550;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;

    // One parse result as it leaves the block.
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] prog_num;
        logic [4:0]  tbl_version;
        logic        current_next;
        logic [7:0]  section_index;
        logic [7:0]  last_section_index;
        logic [12:0] pcr_pid;
        logic [7:0]  entry_type;
        logic [12:0] entry_pid;
        logic [11:0] entry_desc_len;
        logic [31:0] crc_value;
        logic        last_of_section;
    } t_result;

    // Walks the section bytes as the block does and holds the results still owed.
    class t_scoreboard;
        t_phase      phase;
        logic [3:0]  pos;
        logic [11:0] sect_left;
        logic [11:0] loop_left;
        logic [7:0]  desc_left;
        logic [63:0] shift;
        logic [55:0] hold;
        t_result     owed_q[$];
        int          errors;

        function new();
            phase     = PH_IDLE;
            pos       = '0;
            sect_left = '0;
            loop_left = '0;
            desc_left = '0;
            shift     = '0;
            hold      = '0;
            errors    = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void owe_result(t_kind k, logic [7:0] st, logic [12:0] pid,
                                 logic [11:0] esl, logic [31:0] crc, logic last);
            t_result     r;
            logic [55:0] h;
            // The wrong table id result carries no header.
            h = (k == KIND_BAD_TID) ? '0 : hold;
            r.kind               = k;
            r.prog_num           = h[55:40];
            r.tbl_version        = h[37:33];
            r.current_next       = h[32];
            r.section_index      = h[31:24];
            r.last_section_index = h[23:16];
            r.pcr_pid            = h[12:0];
            r.entry_type         = st;
            r.entry_pid          = pid;
            r.entry_desc_len     = esl;
            r.crc_value          = crc;
            r.last_of_section    = last;
            owed_q.push_back(r);
        endfunction

        // Leave a descriptor loop: more than the CRC left means another entry.
        function void close_loop();
            pos   = '0;
            shift = '0;
            phase = (sect_left > CRC_BYTES) ? PH_STREAM : PH_CRC;
        endfunction

        function void end_descriptor();
            if (loop_left != 0) begin
                pos = POS_DESC_TAG;
            end else begin
                close_loop();
            end
        endfunction

        function void descriptor_byte(logic [7:0] b);
            if (sect_left != 0) sect_left--;
            if (loop_left != 0) loop_left--;
            if (pos == POS_DESC_TAG) begin
                pos = POS_DESC_LEN;
            end else if (pos == POS_DESC_LEN) begin
                desc_left = b;
                pos       = POS_DESC_BODY;
                if (desc_left == 0) end_descriptor();
            end else begin
                if (desc_left != 0) desc_left--;
                if (desc_left == 0) end_descriptor();
            end
        endfunction

        // Note one accepted byte; returns 0 when the block merely ignores it.
        function bit note_byte(logic [7:0] b, logic st);
            t_phase entry_phase;
            entry_phase = phase;
            if (st) begin
                sect_left = '0;
                loop_left = '0;
                desc_left = '0;
                shift     = '0;
                hold      = '0;
                pos       = '0;
                if (b != PMT_TABLE_ID) begin
                    phase = PH_IDLE;
                    owe_result(KIND_BAD_TID, '0, '0, '0, '0, 1'b1);
                end else begin
                    phase = PH_HEADER;
                    pos   = 4'd1;
                end
                return 1'b1;
            end
            case (phase)
                PH_HEADER: begin
                    if (pos >= POS_HOLD_LO && pos <= POS_HOLD_HI) begin
                        hold = {hold[47:0], b};
                    end else begin
                        shift = {shift[55:0], b};
                        if (pos == POS_LEN_LO) sect_left = shift[11:0];
                    end
                    if (pos < POS_HDR_LAST) begin
                        pos++;
                    end else begin
                        sect_left = (sect_left > HEADER_TAIL) ? sect_left - HEADER_TAIL : '0;
                        loop_left = shift[11:0];
                        owe_result(KIND_HEADER, '0, '0, '0, '0, 1'b0);
                        if (loop_left != 0) begin
                            phase = PH_PROG_DESC;
                            pos   = POS_DESC_TAG;
                        end else begin
                            close_loop();
                        end
                    end
                end
                PH_PROG_DESC, PH_ES_DESC: descriptor_byte(b);
                PH_STREAM: begin
                    if (sect_left != 0) sect_left--;
                    shift = {shift[55:0], b};
                    if (pos < POS_ENT_LAST) begin
                        pos++;
                    end else begin
                        owe_result(KIND_STREAM, shift[39:32], shift[28:16], shift[11:0],
                                   '0, 1'b0);
                        loop_left = shift[11:0];
                        if (loop_left != 0) begin
                            phase = PH_ES_DESC;
                            pos   = POS_DESC_TAG;
                        end else begin
                            close_loop();
                        end
                    end
                end
                PH_CRC: begin
                    shift = {shift[55:0], b};
                    if (pos < POS_CRC_LAST) begin
                        pos++;
                    end else begin
                        owe_result(KIND_CRC, '0, '0, '0, shift[31:0], 1'b1);
                        phase = PH_IDLE;
                        pos   = '0;
                    end
                end
                default: ;
            endcase
            return entry_phase != PH_IDLE;
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report($sformatf("%s got 0x%0h, want 0x%0h", name, got_v, want_v));
        endtask

        task check_result(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                report($sformatf("result of kind %0d with none owed", got.kind));
                return;
            end
            want = owed_q.pop_front();
            compare("result_kind", 32'(got.kind), 32'(want.kind));
            compare("prog_num", 32'(got.prog_num), 32'(want.prog_num));
            compare("tbl_version", 32'(got.tbl_version), 32'(want.tbl_version));
            compare("current_next", 32'(got.current_next), 32'(want.current_next));
            compare("section_index", 32'(got.section_index), 32'(want.section_index));
            compare("last_section_index", 32'(got.last_section_index),
                    32'(want.last_section_index));
            compare("pcr_pid", 32'(got.pcr_pid), 32'(want.pcr_pid));
            compare("entry_type", 32'(got.entry_type), 32'(want.entry_type));
            compare("entry_pid", 32'(got.entry_pid), 32'(want.entry_pid));
            compare("entry_desc_len", 32'(got.entry_desc_len), 32'(want.entry_desc_len));
            compare("crc_value", got.crc_value, want.crc_value);
            compare("last_of_section", 32'(got.last_of_section), 32'(want.last_of_section));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    pmt_byte_if   byte_ch ();
    pmt_result_if res_ch ();

    pmt_section_parser_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_res   (res_ch)
    );

    t_scoreboard sb = new();

    bit          in_idle;
    bit          out_idle;
    int          used_items;
    int          cycles;
    logic [8:0]  sect_q[$];   // {section_start, data_byte}
    t_result     seen;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_pmt_section_parser_core failed");
            $finish;
        end
    end

    // Note every accepted byte; count only those the block acts on.
    always @(posedge i_clk) begin
        if (byte_ch.valid && byte_ch.ready) begin
            if (sb.note_byte(byte_ch.data_byte, byte_ch.section_start)) used_items++;
        end
    end

    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) begin
            seen.kind               = res_ch.result_kind;
            seen.prog_num           = res_ch.prog_num;
            seen.tbl_version        = res_ch.tbl_version;
            seen.current_next       = res_ch.current_next;
            seen.section_index      = res_ch.section_index;
            seen.last_section_index = res_ch.last_section_index;
            seen.pcr_pid            = res_ch.pcr_pid;
            seen.entry_type         = res_ch.entry_type;
            seen.entry_pid          = res_ch.entry_pid;
            seen.entry_desc_len     = res_ch.entry_desc_len;
            seen.crc_value          = res_ch.crc_value;
            seen.last_of_section    = res_ch.last_of_section;
            sb.check_result(seen);
        end
    end

    // Result sink: while out_idle is set, stall a random number of cycles before each result.
    initial begin
        int unsigned gap;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = out_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // Zero, all ones, or a random value of the given width.
    function automatic logic [31:0] pick_field(int unsigned w);
        logic [31:0] m;
        m = (32'h1 << w) - 1;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return m;
            default: return $urandom & m;
        endcase
    endfunction

    // Hold valid across back-to-back items; drop it only for a gap.
    task automatic send_byte(input logic [7:0] b, input logic s);
        int unsigned gap;
        gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.section_start <= s;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic send_queue();
        foreach (sect_q[i]) send_byte(sect_q[i][7:0], sect_q[i][8]);
        sect_q.delete();
    endtask

    // Stop sending until every owed result has come back.
    task automatic wait_results();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic push_header(input logic [11:0] slen, input logic [11:0] plen,
                               input logic [15:0] pnum, input logic [4:0] ver,
                               input logic cn, input logic [7:0] sec,
                               input logic [7:0] lsec, input logic [12:0] pcr);
        sect_q.push_back({1'b1, PMT_TABLE_ID});
        sect_q.push_back({1'b0, 4'($urandom), slen[11:8]});
        sect_q.push_back({1'b0, slen[7:0]});
        sect_q.push_back({1'b0, pnum[15:8]});
        sect_q.push_back({1'b0, pnum[7:0]});
        sect_q.push_back({1'b0, 2'($urandom), ver, cn});
        sect_q.push_back({1'b0, sec});
        sect_q.push_back({1'b0, lsec});
        sect_q.push_back({1'b0, 3'($urandom), pcr[12:8]});
        sect_q.push_back({1'b0, pcr[7:0]});
        sect_q.push_back({1'b0, 4'($urandom), plen[11:8]});
        sect_q.push_back({1'b0, plen[7:0]});
    endtask

    // Tag, length and body; now and then the longest body there is.
    function automatic void add_descriptor(ref logic [7:0] q[$]);
        int unsigned len;
        len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 6);
        q.push_back(8'(pick_field(8)));
        q.push_back(8'(len));
        repeat (len) q.push_back(8'($urandom));
    endfunction

    // Mostly well-formed sections; the rest bent, truncated or followed by noise.
    task automatic build_section();
        logic [7:0]  prog_q[$];
        logic [7:0]  loop_q[$];
        logic [7:0]  desc_q[$];
        logic [11:0] slen;
        logic [11:0] plen;
        logic [12:0] pid;
        logic [7:0]  tid;
        int unsigned pick;
        int unsigned keep;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            tid = 8'($urandom);
            if (tid == PMT_TABLE_ID) tid = ~tid;
            sect_q.push_back({1'b1, tid});
            repeat ($urandom_range(0, 4)) sect_q.push_back({1'b0, 8'($urandom)});
            return;
        end
        repeat ($urandom_range(0, 2)) add_descriptor(prog_q);
        repeat ($urandom_range(0, 5)) begin
            desc_q.delete();
            repeat ($urandom_range(0, 2)) add_descriptor(desc_q);
            pid = 13'(pick_field(13));
            loop_q.push_back(8'(pick_field(8)));
            loop_q.push_back({3'($urandom), pid[12:8]});
            loop_q.push_back(pid[7:0]);
            loop_q.push_back({4'($urandom), 4'(desc_q.size() >> 8)});
            loop_q.push_back(8'(desc_q.size()));
            foreach (desc_q[i]) loop_q.push_back(desc_q[i]);
        end
        plen = 12'(prog_q.size());
        slen = 12'(9 + prog_q.size() + loop_q.size() + 4);
        // Program info length short of its descriptors: the loop overruns.
        if (pick == 1 && plen > 2) plen = 12'($urandom_range(1, plen - 1));
        if (pick == 2) slen = 12'($urandom_range(0, 8));
        if (pick == 3) begin
            slen = 12'(pick_field(12));
            plen = 12'(pick_field(12));
        end
        push_header(slen, plen, 16'(pick_field(16)), 5'(pick_field(5)), 1'($urandom),
                    8'(pick_field(8)), 8'(pick_field(8)), 13'(pick_field(13)));
        foreach (prog_q[i]) sect_q.push_back({1'b0, prog_q[i]});
        foreach (loop_q[i]) sect_q.push_back({1'b0, loop_q[i]});
        repeat (4) sect_q.push_back({1'b0, 8'(pick_field(8))});
        // Cut the section short; the next start abandons it.
        if (pick == 3 || pick == 4) begin
            keep = $urandom_range(1, sect_q.size());
            while (sect_q.size() > keep) void'(sect_q.pop_back());
        end
        if (pick == 5) begin
            repeat ($urandom_range(1, 6))
                sect_q.push_back({1'($urandom_range(0, 3) == 0), 8'($urandom)});
        end else if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) sect_q.push_back({1'b0, 8'($urandom)});
        end
    endtask

    initial begin
        int base;
        i_rst_n               <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.data_byte     <= '0;
        byte_ch.section_start <= 1'b0;
        cycles                = 0;
        used_items            = 0;
        in_idle               = 1'b0;
        out_idle              = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes while idle, then two wrong table ids and a stray id without start.
        sect_q.push_back({1'b0, 8'h00});
        sect_q.push_back({1'b0, 8'hFF});
        sect_q.push_back({1'b1, 8'hFF});
        sect_q.push_back({1'b1, 8'h00});
        sect_q.push_back({1'b0, PMT_TABLE_ID});
        // Header fields at their maxima, no program info, no entries.
        push_header(12'd13, 12'd0, 16'hFFFF, 5'h1F, 1'b1, 8'hFF, 8'hFF, 13'h1FFF);
        repeat (4) sect_q.push_back({1'b0, 8'hFF});
        // Section length below the header tail, all-zero fields.
        push_header(12'd5, 12'd0, 16'h0000, 5'h00, 1'b0, 8'h00, 8'h00, 13'h0000);
        repeat (4) sect_q.push_back({1'b0, 8'h00});
        // Program descriptor longer than its loop, then one entry with type and pid at their maxima.
        push_header(12'd25, 12'd3, 16'h1234, 5'h0A, 1'b1, 8'h01, 8'h02, 13'h0100);
        sect_q.push_back({1'b0, 8'h0A});
        sect_q.push_back({1'b0, 8'h05});
        repeat (5) sect_q.push_back({1'b0, 8'($urandom)});
        sect_q.push_back({1'b0, 8'hFF});
        sect_q.push_back({1'b0, 8'hFF});
        sect_q.push_back({1'b0, 8'hFF});
        sect_q.push_back({1'b0, 8'hF0});
        sect_q.push_back({1'b0, 8'h00});
        repeat (4) sect_q.push_back({1'b0, 8'($urandom)});
        // Start a new section in the middle of the header of another.
        push_header(12'd13, 12'd0, 16'h5555, 5'h15, 1'b0, 8'hAA, 8'h55, 13'h0AAA);
        repeat (8) void'(sect_q.pop_back());
        push_header(12'd13, 12'd0, 16'hAAAA, 5'h0A, 1'b1, 8'h55, 8'hAA, 13'h1555);
        repeat (4) sect_q.push_back({1'b0, 8'($urandom)});
        send_queue();
        wait_results();

        // Random sections in four stretches: no idling, sender gaps, sink stalls, both.
        base = used_items;
        for (int ph = 0; ph < 4; ph++) begin
            in_idle  = ph[0];
            out_idle = ph[1];
            while (used_items < base + (ITEM_TARGET * (ph + 1)) / 4) begin
                build_section();
                send_queue();
            end
            wait_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb_pmt_section_parser_core passed");
        end else begin
            $display("tb_pmt_section_parser_core failed");
        end
        $finish;
    end

endmodule : tb_pmt_section_parser_core

`default_nettype wire

// ----- filelist.f -----
hw/rtl/pmt_pkg.sv
hw/rtl/pmt_stream_if.sv
hw/rtl/pmt_section_parser_core.sv
tb/tb_pmt_section_parser_core.sv
